@@ src/min_cost_volume_cover_dp_unit_assert.svh @@
// Assertion macros shared by the min-cost volume cover unit.
`ifndef MIN_COST_VOLUME_COVER_DP_UNIT_ASSERT_SVH
`define MIN_COST_VOLUME_COVER_DP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define MCVC_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mcvc check failed");
// next-cycle implication
`define MCVC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mcvc check failed");
`else
`define MCVC_ASSERT_NOW(label, cond, prop)
`define MCVC_ASSERT_NEXT(label, cond, prop)
`endif
`endif

@@ src/mcvc_pkg.sv @@
// Shared widths, types and controller/datapath interface for the cover unit.
package mcvc_pkg;

    localparam int MAX_VOLUME  = 1024;
    localparam int IDX_W       = $clog2(MAX_VOLUME);
    localparam int COST_W      = 27;
    localparam int VAR_W       = 8;
    localparam int ITEM_COST_W = 16;
    localparam int ITEM_VOL_W  = 11;
    localparam int TARGET_W    = 11;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    localparam logic [COST_W-1:0] INF_COST  = COST_W'(100000000);
    localparam logic [VAR_W-1:0]  MAX_KINDS = VAR_W'(128);

    typedef struct packed {
        logic [VAR_W-1:0]  variety;
        logic [COST_W-1:0] cost;
    } entry_t;

    typedef struct packed {
        logic start;     // latch the item, reset the sweep index
        logic issue;     // issue one volume entry into the pipeline
        logic flip;      // swap row banks after the sweep
        logic fetch;     // read the target entry
        logic load_out;  // load the output register
    } cmd_t;

    typedef struct packed {
        logic last_issue; // issuing the last volume entry
        logic busy;       // pipeline still holds entries
    } status_t;

endpackage

@@ src/min_cost_volume_cover_dp_unit.sv @@
// Top level of the min-cost volume cover unit.
// Minimum-cost volume cover (unbounded knapsack): each input word brings one
// item kind (cost per portion, volume per portion, and first_of_set in tuser,
// which starts a new problem). The unit refreshes the whole best-cost row for
// volumes 1..1024, keeping per volume the least cost that covers at least that
// volume and, on equal cost, the most distinct kinds; costs saturate at
// 100000000, which also means "not coverable". Each input produces one output
// word with the least cost and variety for the configured target volume (clamped
// to 1024; a target of 0 gives 0/0). Each item first sweeps the whole row, one
// volume entry per cycle through a four-stage pipeline over the row memories,
// then drains the pipeline and swaps the banks, then reads the target entry and
// loads the output register. Items are processed one at a time; s_tready is high
// only while the unit is idle, and the finished result sits in an output register,
// so the next item is taken while it waits.
// Two banks of the best row ping-pong (read old, write new); a cleared bank is
// tracked by a flag, so there is no clearing pass after reset or first_of_set.
// target_volume is written through cfg_valid/cfg_data (always ready) and must
// only change while the unit is idle.
module min_cost_volume_cover_dp_unit
    import mcvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input word
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] item_cost, [26:16] item_volume
    input  logic                 s_tuser,   // [0] first_of_set
    // output word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [26:0] cover_cost, [34:27] variety
    // target_volume register
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TARGET_W-1:0]  cfg_data
);

    cmd_t              cmd;
    status_t           status;
    logic [COST_W-1:0] cover_cost;
    logic [VAR_W-1:0]  variety;

    // config writes are taken at any time
    assign cfg_ready = 1'b1;

    mcvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mcvc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_cost    (s_tdata[ITEM_COST_W-1:0]),
        .item_volume  (s_tdata[ITEM_COST_W +: ITEM_VOL_W]),
        .first_of_set (s_tuser),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .cover_cost   (cover_cost),
        .variety      (variety)
    );

    assign m_tdata = {(M_TDATA_W-COST_W-VAR_W)'(0), variety, cover_cost};

endmodule

@@ src/mcvc_ctrl.sv @@
// Sequencer for the cover unit: accept, sweep, drain, fetch, deliver.
module mcvc_ctrl
    import mcvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SWEEP   = 5'b00010,
        S_DRAIN   = 5'b00100,
        S_FETCH   = 5'b01000,
        S_DELIVER = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.busy)
                begin
                    cmd.flip   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`include "min_cost_volume_cover_dp_unit_assert.svh"

    `MCVC_ASSERT_NEXT(a_accept_starts_sweep, s_tvalid && s_tready, state_reg == S_SWEEP)
    `MCVC_ASSERT_NEXT(a_last_issue_drains, (state_reg == S_SWEEP) && status.last_issue, state_reg == S_DRAIN)
    `MCVC_ASSERT_NEXT(a_deliver_waits, (state_reg == S_DELIVER) && out_valid_reg && !m_tready, state_reg == S_DELIVER)

endmodule

@@ src/mcvc_datapath.sv @@
// Row banks, with-kind row, four-stage update pipeline and result register.
module mcvc_datapath
    import mcvc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ITEM_COST_W-1:0] item_cost,
    input  logic [ITEM_VOL_W-1:0]  item_volume,
    input  logic                   first_of_set,
    input  logic                   cfg_we,
    input  logic [TARGET_W-1:0]    cfg_data,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic [COST_W-1:0]      cover_cost,
    output logic [VAR_W-1:0]       variety
);

    localparam entry_t ZERO_E = '{variety: '0, cost: '0};
    localparam entry_t INF_E  = '{variety: '0, cost: INF_COST};

    function automatic entry_t sat_add(entry_t a, logic [ITEM_COST_W-1:0] c);
        logic [COST_W:0] sum;
        entry_t          r;
        sum       = {1'b0, a.cost} + (COST_W+1)'(c);
        r.cost    = (sum > {1'b0, INF_COST}) ? INF_COST : sum[COST_W-1:0];
        r.variety = a.variety;
        return r;
    endfunction

    function automatic logic [VAR_W-1:0] sat_inc(logic [VAR_W-1:0] v);
        return (v >= MAX_KINDS) ? MAX_KINDS : v + VAR_W'(1);
    endfunction

    // cheaper wins, a tie keeps the larger variety
    function automatic entry_t pick(entry_t a, entry_t b);
        entry_t r;
        if (a.cost < b.cost)
        begin
            r = a;
        end
        else if (b.cost < a.cost)
        begin
            r = b;
        end
        else
        begin
            r.cost    = a.cost;
            r.variety = (a.variety > b.variety) ? a.variety : b.variety;
        end
        return r;
    endfunction

    // memories: entries 1..MAX_VOLUME stored at index volume-1, volume 0 is constant
    entry_t best_mem [0:2*MAX_VOLUME-1];
    entry_t with_mem [0:MAX_VOLUME-1];

    logic [ITEM_COST_W-1:0] cost_reg;
    logic [ITEM_VOL_W-1:0]  vol_reg;
    logic                   prev_clear_reg;
    logic                   bank_reg;
    logic [TARGET_W-1:0]    target_reg;
    logic [IDX_W-1:0]       idx_reg;

    logic                   vol_zero;
    logic                   rem_zero;
    logic                   fwd1;
    logic                   fwd2;
    logic [IDX_W-1:0]       rem_idx;
    logic [TARGET_W-1:0]    t_sat;
    logic                   t_zero;
    logic [IDX_W-1:0]       t_idx;
    logic [IDX_W-1:0]       a_idx;

    entry_t rd_a_reg, rd_b_reg, rd_w_reg;

    logic             s1_valid_reg, s1_remz_reg, s1_fwd1_reg, s1_fwd2_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_valid_reg, s2_remz_reg, s2_fwd1_reg, s2_fwd2_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    entry_t           s2_oc_reg, s2_bpj_reg, s2_wmem_reg;
    logic             s3_valid_reg;
    logic [IDX_W-1:0] s3_idx_reg;
    entry_t           s3_wc_reg, s3_bpj_reg;
    entry_t           s4_wc_reg;

    entry_t bp_rem, bp_j, oc, w_rem, mc, wc, bc;

    logic [COST_W-1:0] cover_cost_reg;
    logic [VAR_W-1:0]  variety_reg;

    // issue stage: volume j = idx+1, remainder j-vol
    assign vol_zero = (vol_reg == '0);
    assign rem_zero = ({1'b0, idx_reg} < vol_reg);
    assign fwd1     = (vol_reg == ITEM_VOL_W'(1));
    assign fwd2     = (vol_reg == ITEM_VOL_W'(2));
    assign rem_idx  = idx_reg - vol_reg[IDX_W-1:0];

    assign t_sat  = (target_reg > TARGET_W'(MAX_VOLUME)) ? TARGET_W'(MAX_VOLUME) : target_reg;
    assign t_zero = (target_reg == '0);
    assign t_idx  = IDX_W'(t_sat - TARGET_W'(1));
    assign a_idx  = cmd.fetch ? t_idx : rem_idx;

    assign status.last_issue = (idx_reg == IDX_W'(MAX_VOLUME - 1));
    assign status.busy       = s1_valid_reg | s2_valid_reg | s3_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clear_reg <= 1'b1;
            bank_reg       <= 1'b0;
            target_reg     <= TARGET_W'(1);
            idx_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                target_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                idx_reg <= '0;
                if (first_of_set)
                begin
                    prev_clear_reg <= 1'b1;
                end
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.flip)
            begin
                bank_reg       <= ~bank_reg;
                prev_clear_reg <= 1'b0;
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // item payload and pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cost_reg <= item_cost;
            vol_reg  <= item_volume;
        end
        s1_idx_reg  <= idx_reg;
        s1_remz_reg <= rem_zero;
        s1_fwd1_reg <= fwd1;
        s1_fwd2_reg <= fwd2;

        s2_idx_reg  <= s1_idx_reg;
        s2_remz_reg <= s1_remz_reg;
        s2_fwd1_reg <= s1_fwd1_reg;
        s2_fwd2_reg <= s1_fwd2_reg;
        s2_oc_reg   <= oc;
        s2_bpj_reg  <= bp_j;
        s2_wmem_reg <= rd_w_reg;

        s3_idx_reg <= s2_idx_reg;
        s3_wc_reg  <= wc;
        s3_bpj_reg <= s2_bpj_reg;
        s4_wc_reg  <= s3_wc_reg;

        if (cmd.load_out)
        begin
            cover_cost_reg <= t_zero ? '0 : rd_a_reg.cost;
            variety_reg    <= t_zero ? '0 : rd_a_reg.variety;
        end
    end

    // best rows: read prev bank at remainder and at j, write next bank
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            best_mem[{~bank_reg, s3_idx_reg}] <= bc;
        end
        if (cmd.issue || cmd.fetch)
        begin
            rd_a_reg <= best_mem[{bank_reg, a_idx}];
        end
        if (cmd.issue)
        begin
            rd_b_reg <= best_mem[{bank_reg, idx_reg}];
        end
    end

    // with-kind row
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            with_mem[s2_idx_reg] <= wc;
        end
        if (cmd.issue)
        begin
            rd_w_reg <= with_mem[rem_idx];
        end
    end

    // stage 1: a cleared bank reads as infinity, volume 0 as zero
    always_comb
    begin
        bp_rem = s1_remz_reg ? ZERO_E : (prev_clear_reg ? INF_E : rd_a_reg);
        bp_j   = prev_clear_reg ? INF_E : rd_b_reg;
        oc         = sat_add(bp_rem, cost_reg);
        oc.variety = sat_inc(bp_rem.variety);
    end

    // stage 2: remainder entries not yet readable from the with-kind row are forwarded from s3_wc_reg and s4_wc_reg
    always_comb
    begin
        if (s2_remz_reg)
        begin
            w_rem = ZERO_E;
        end
        else if (s2_fwd1_reg)
        begin
            w_rem = s3_wc_reg;
        end
        else if (s2_fwd2_reg)
        begin
            w_rem = s4_wc_reg;
        end
        else
        begin
            w_rem = s2_wmem_reg;
        end
        mc = sat_add(w_rem, cost_reg);
        wc = vol_zero ? INF_E : pick(s2_oc_reg, mc);
    end

    // stage 3
    assign bc = pick(s3_wc_reg, s3_bpj_reg);

    assign cover_cost = cover_cost_reg;
    assign variety    = variety_reg;

`include "min_cost_volume_cover_dp_unit_assert.svh"

    `MCVC_ASSERT_NOW(a_pipe_no_gap, s1_valid_reg && s3_valid_reg, s2_valid_reg)
    `MCVC_ASSERT_NOW(a_flip_when_empty, cmd.flip, !status.busy)
    `MCVC_ASSERT_NOW(a_fetch_from_valid_bank, cmd.fetch, !prev_clear_reg && !status.busy)

endmodule

@@ tb/min_cost_volume_cover_dp_unit_tb.sv @@
// Self-checking testbench for the min-cost volume cover unit.
module min_cost_volume_cover_dp_unit_tb;
    import mcvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no word moved on any channel before the run is abandoned;
    // it must outlast the processing of one item plus any output stall
    localparam int unsigned WATCHDOG_LIMIT = 8000;
    // quiet cycles after the last result, to catch stray output words
    localparam int unsigned DRAIN_CYCLES   = 64;
    // seven in a hundred chance per cycle that a side idles
    localparam int unsigned IDLE_PERCENT   = 7;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata    = '0;  // [15:0] item_cost, [26:16] item_volume
    logic                 s_tuser    = 1'b0; // [0] first_of_set
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [26:0] cover_cost, [34:27] variety
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [TARGET_W-1:0]  cfg_data   = '0;

    // no random idling on either side while set
    bit          calm;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // predicted cover per accepted item, oldest first
    entry_t expected_cover[$];

    // predictor state: two banks of the best row, the row that uses the
    // current kind at least once, the live bank and the target register
    entry_t              best_row [2][MAX_VOLUME+1];
    entry_t              with_kind_row [MAX_VOLUME+1];
    bit                  live_bank;
    logic [TARGET_W-1:0] cover_target;

    min_cost_volume_cover_dp_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [COST_W-1:0] cost_sum(input logic [COST_W-1:0] a,
                                                   input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, INF_COST}) ? INF_COST : s[COST_W-1:0];
    endfunction

    function automatic logic [VAR_W-1:0] kinds_inc(input logic [VAR_W-1:0] a);
        return (a >= MAX_KINDS) ? MAX_KINDS : a + 1'b1;
    endfunction

    // cheaper of two; equal cost keeps the larger variety
    function automatic entry_t cheaper(input entry_t a, input entry_t b);
        entry_t r;
        if (a.cost < b.cost)
            r = a;
        else if (b.cost < a.cost)
            r = b;
        else
        begin
            r.cost    = a.cost;
            r.variety = (a.variety > b.variety) ? a.variety : b.variety;
        end
        return r;
    endfunction

    function automatic void clear_best_bank(input bit bank);
        for (int j = 0; j <= MAX_VOLUME; j++)
        begin
            best_row[bank][j].cost    = (j == 0) ? '0 : INF_COST;
            best_row[bank][j].variety = '0;
        end
    endfunction

    function automatic void cover_reset();
        clear_best_bank(1'b0);
        clear_best_bank(1'b1);
        for (int j = 0; j <= MAX_VOLUME; j++)
        begin
            with_kind_row[j].cost    = (j == 0) ? '0 : INF_COST;
            with_kind_row[j].variety = '0;
        end
        live_bank    = 1'b0;
        cover_target = TARGET_W'(1);
    endfunction

    // adds one item kind to the tables and returns the cover at the target
    function automatic entry_t cover_add_kind(input logic [ITEM_COST_W-1:0] cost,
                                              input logic [ITEM_VOL_W-1:0]  vol,
                                              input logic                   first);
        bit          nxt;
        int          rem;
        int          t;
        entry_t      once;
        entry_t      more;
        entry_t      with_kind;
        entry_t      best;
        logic [COST_W-1:0] c;
        c = COST_W'(cost);
        if (first)
            clear_best_bank(live_bank);
        nxt = ~live_bank;
        with_kind_row[0]   = '0;
        best_row[nxt][0]   = best_row[live_bank][0];
        for (int j = 1; j <= MAX_VOLUME; j++)
        begin
            if (vol == '0)
            begin
                // a kind of no volume covers nothing
                with_kind.cost    = INF_COST;
                with_kind.variety = '0;
                best              = best_row[live_bank][j];
            end
            else
            begin
                rem          = (j > int'(vol)) ? j - int'(vol) : 0;
                once.cost    = cost_sum(best_row[live_bank][rem].cost, c);
                once.variety = kinds_inc(best_row[live_bank][rem].variety);
                more.cost    = cost_sum(with_kind_row[rem].cost, c);
                more.variety = with_kind_row[rem].variety;
                with_kind    = cheaper(once, more);
                best         = cheaper(with_kind, best_row[live_bank][j]);
            end
            with_kind_row[j] = with_kind;
            best_row[nxt][j] = best;
        end
        live_bank = nxt;
        t = (int'(cover_target) > MAX_VOLUME) ? MAX_VOLUME : int'(cover_target);
        return best_row[live_bank][t];
    endfunction

    // ------------------------------------------------------------------
    // Drivers and checker
    // ------------------------------------------------------------------

    // output side stalls at random, driven at the falling edge
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);

    // each output word is compared with the oldest prediction
    always @(posedge clk)
    begin : check_output
        entry_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cover.size() == 0)
            begin
                $display("%0t: output word with none expected, actual cost %0d variety %0d",
                         $time, m_tdata[COST_W-1:0], m_tdata[COST_W+VAR_W-1:COST_W]);
                mismatch_count++;
            end
            else
            begin
                want = expected_cover.pop_front();
                if (m_tdata[COST_W-1:0] !== want.cost)
                begin
                    $display("%0t: cover cost mismatch, expected %0d, actual %0d",
                             $time, want.cost, m_tdata[COST_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[COST_W+VAR_W-1:COST_W] !== want.variety)
                begin
                    $display("%0t: variety mismatch, expected %0d, actual %0d",
                             $time, want.variety, m_tdata[COST_W+VAR_W-1:COST_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // any word moved on any channel restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sends one item kind. Called at a falling edge; returns at the falling
    // edge after the word was taken, with tvalid still high so a following
    // item goes out without a gap.
    task automatic send_kind(input logic [ITEM_COST_W-1:0] cost,
                             input logic [ITEM_VOL_W-1:0]  vol,
                             input logic                   first);
        while (!calm && ($urandom_range(99) < IDLE_PERCENT))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({vol, cost});
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_cover.push_back(cover_add_kind(cost, vol, first));
        @(negedge clk);
    endtask

    // drops the input and waits until every predicted word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_cover.size() != 0)
            @(negedge clk);
    endtask

    // target_volume write; only while the unit is idle
    task automatic write_target(input logic [TARGET_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cover_target = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TARGET_W-1:0] random_target();
        case ($urandom_range(3))
            0:       return TARGET_W'($urandom_range(1, 32));
            1:       return TARGET_W'($urandom_range(1, MAX_VOLUME));
            2:       return TARGET_W'($urandom_range(100, 300));
            default:
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return TARGET_W'(MAX_VOLUME);
                    2:       return '1;
                    default: return TARGET_W'($urandom_range(MAX_VOLUME + 1, 2047));
                endcase
        endcase
    endfunction

    // mostly cheap small kinds so that sums and ties matter,
    // with the full field ranges mixed in
    task automatic send_random_kind(input logic first);
        logic [ITEM_COST_W-1:0] cost;
        logic [ITEM_VOL_W-1:0]  vol;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: cost = ITEM_COST_W'($urandom_range(0, 50));
            6, 7:             cost = ITEM_COST_W'($urandom);
            8:                cost = $urandom_range(1) ? '1 : '0;
            default:          cost = ITEM_COST_W'($urandom_range(51, 4000));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: vol = ITEM_VOL_W'($urandom_range(1, 40));
            7:                   vol = ITEM_VOL_W'($urandom_range(1, MAX_VOLUME));
            8:                   vol = ITEM_VOL_W'($urandom);
            default:
                case ($urandom_range(3))
                    0:       vol = '0;
                    1:       vol = ITEM_VOL_W'(MAX_VOLUME);
                    2:       vol = ITEM_VOL_W'(MAX_VOLUME + 1);
                    default: vol = '1;
                endcase
        endcase
        send_kind(cost, vol, first);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // field extremes, zero and oversized volumes, every target corner
    task automatic test_directed();
        // reset target of 1, no set start: reset tables act as cleared
        send_kind(16'd5, 11'd1, 1'b0);
        send_kind(16'hFFFF, 11'h7FF, 1'b0);
        send_kind(16'd0, 11'd0, 1'b0);
        wait_drained();
        write_target(TARGET_W'(0));
        send_kind(16'd7, 11'd3, 1'b1);
        wait_drained();
        write_target(TARGET_W'(MAX_VOLUME));
        // no-volume kind alone leaves the target uncoverable
        send_kind(16'd9, 11'd0, 1'b1);
        send_kind(16'd3, 11'd1000, 1'b1);
        send_kind(16'd2, 11'd24, 1'b0);
        send_kind(16'hFFFF, 11'd1023, 1'b0);
        send_kind(16'd0, 11'h7FF, 1'b0);
        wait_drained();
        write_target('1);
        send_kind(16'hFFFF, 11'd1, 1'b1);
        send_kind(16'hFFFF, 11'd1024, 1'b0);
        send_kind(16'd0, 11'd1025, 1'b0);
        // two identical kinds tie; variety must grow
        send_kind(16'd1, 11'd2, 1'b1);
        send_kind(16'd1, 11'd2, 1'b0);
        send_kind(16'd100, 11'd0, 1'b0);
        wait_drained();
        write_target(TARGET_W'(MAX_VOLUME + 1));
        send_kind(16'd1, 11'd512, 1'b1);
        send_kind(16'd1, 11'd512, 1'b0);
        wait_drained();
        write_target(TARGET_W'(1));
        send_kind(16'hAAAA, 11'h555, 1'b1);
        send_kind(16'h5555, 11'h2AA, 1'b0);
        wait_drained();
    endtask

    // well-formed sets of random kinds, a few stray set starts as noise
    task automatic test_random_sets();
        int unsigned sent;
        int unsigned set_len;
        for (int phase = 0; phase < 10; phase++)
        begin
            wait_drained();
            write_target(random_target());
            calm = (phase == 3) || (phase == 4);
            sent = 0;
            while (sent < 41)
            begin
                set_len = $urandom_range(1, 10);
                for (int k = 0; k < set_len; k++)
                begin
                    if (k == 0)
                        send_random_kind(1'b1);
                    else
                        send_random_kind(($urandom_range(99) < 5) ? 1'b1 : 1'b0);
                    sent++;
                end
            end
        end
        calm = 1'b0;
        wait_drained();
    endtask

    // free kinds of small volume all tie at cost zero and together stay
    // below the largest target, so the kind count passes the variety ceiling
    task automatic test_variety_ceiling();
        write_target(TARGET_W'(MAX_VOLUME));
        for (int k = 0; k < 135; k++)
            send_kind('0, ITEM_VOL_W'($urandom_range(1, 4)), k == 0);
        wait_drained();
    endtask

    initial
    begin
        cover_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_sets();
        test_variety_ceiling();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_cover.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
